[design/matrix4x4_row_transform_assert.svh]
// Assertion macros for the 4x4 row transform block.
`ifndef MATRIX4X4_ROW_TRANSFORM_ASSERT_SVH
`define MATRIX4X4_ROW_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define M4RT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("m4rt assertion failed");
// Next-cycle implication.
`define M4RT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("m4rt assertion failed");
`else
`define M4RT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define M4RT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/m4rt_pkg.sv]
// Types and constants shared by the 4x4 row transform block.
package m4rt_pkg;

	localparam int DIM       = 4;
	localparam int ELEM_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int FIELD_W   = 32;
	localparam int SLOT_W    = 32;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;
	localparam int N_CFG     = 8;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = $clog2(N_CFG);

	typedef logic signed [ELEM_W-1:0]  elem_t;
	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [PAIR_W-1:0]  pair_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [CFG_W-1:0]          cfg_word_t;

	typedef elem_t elem_row_t [DIM];
	typedef elem_row_t elem_mat_t [DIM];
	typedef prod_t prod_row_t [DIM];
	typedef prod_row_t prod_mat_t [DIM];
	typedef pair_t pair_row_t [DIM/2];
	typedef pair_row_t pair_mat_t [DIM];
	typedef sum_t sum_row_t [DIM];
	typedef field_t field_row_t [DIM];

	localparam elem_t ELEM_MAX = elem_t'({1'b0, {(ELEM_W-1){1'b1}}});
	localparam elem_t ELEM_MIN = elem_t'({1'b1, {(ELEM_W-1){1'b0}}});
	localparam field_t FIELD_MAX = field_t'(ELEM_MAX);
	localparam field_t FIELD_MIN = field_t'(ELEM_MIN);

	localparam cfg_word_t ONE_Q = cfg_word_t'(1) << FRAC_BITS;

	// Identity on reset: the unit sits in the low slot for even columns, high for odd.
	localparam cfg_word_t CFG_RESET [N_CFG] = '{
		ONE_Q,
		cfg_word_t'(0),
		ONE_Q << SLOT_W,
		cfg_word_t'(0),
		cfg_word_t'(0),
		ONE_Q,
		cfg_word_t'(0),
		ONE_Q << SLOT_W
	};

endpackage

[design/m4rt_in_if.sv]
// Input row channel: valid/ready with four left-matrix elements.
interface m4rt_in_if;
	logic                          valid;
	logic                          ready;
	logic signed [m4rt_pkg::FIELD_W-1:0] a_elem0;
	logic signed [m4rt_pkg::FIELD_W-1:0] a_elem1;
	logic signed [m4rt_pkg::FIELD_W-1:0] a_elem2;
	logic signed [m4rt_pkg::FIELD_W-1:0] a_elem3;

	modport source (output valid, a_elem0, a_elem1, a_elem2, a_elem3, input ready);
	modport sink (input valid, a_elem0, a_elem1, a_elem2, a_elem3, output ready);
endinterface

[design/m4rt_out_if.sv]
// Result row channel: valid/ready with four result elements and a clip flag.
interface m4rt_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [m4rt_pkg::FIELD_W-1:0] res_elem0;
	logic signed [m4rt_pkg::FIELD_W-1:0] res_elem1;
	logic signed [m4rt_pkg::FIELD_W-1:0] res_elem2;
	logic signed [m4rt_pkg::FIELD_W-1:0] res_elem3;
	logic                          saturated;

	modport source (output valid, res_elem0, res_elem1, res_elem2, res_elem3, saturated,
		input ready);
	modport sink (input valid, res_elem0, res_elem1, res_elem2, res_elem3, saturated,
		output ready);
endinterface

[design/matrix4x4_row_transform.sv]
// Top level of the 4x4 row transform: config registers and the four-stage pipeline.
//
//  channel   dir  handshake      payload
//  row_in    in   valid/ready    a_elem0..a_elem3 (signed Q16.16)
//  row_out   out  valid/ready    res_elem0..res_elem3, saturated
//  cfg       in   cfg_we only    cfg_index, cfg_data (64 bits)
//
// One row per cycle while row_out is not stalled; an accepted word is registered in s1,
// s2, s3 and s4 in turn and is valid at row_out once it sits in s4.
// Stages: multiply, pair add, column add, shift and clip with the output register.
// Each stage advances when it is empty or the next one takes its word, so a stalled
// output holds every word in place and back-pressure reaches row_in.ready.
// Reset clears all stage valids and loads the identity into the right matrix.
`include "matrix4x4_row_transform_assert.svh"

module matrix4x4_row_transform (
	input  logic                              clk,
	input  logic                              arst_n,
	m4rt_in_if.sink                           row_in,
	m4rt_out_if.source                        row_out,
	input  logic                              cfg_we,
	input  logic [m4rt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [m4rt_pkg::CFG_W-1:0]        cfg_data
);

	m4rt_pkg::cfg_word_t  b_q [m4rt_pkg::N_CFG];
	m4rt_pkg::elem_mat_t  b_mat;
	m4rt_pkg::elem_row_t  a_row;
	m4rt_pkg::prod_mat_t  prod_s1;
	m4rt_pkg::sum_row_t   sum_s3;
	m4rt_pkg::field_row_t res_s4;
	logic                 sat_s4;
	logic                 v_s1;
	logic                 rdy_s1;
	logic                 v_s3;
	logic                 rdy_s3;
	logic                 any_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < m4rt_pkg::N_CFG; i++) begin
				b_q[i] <= m4rt_pkg::CFG_RESET[i];
			end
		end else if (cfg_we) begin
			b_q[cfg_index] <= cfg_data;
		end
	end

	// B[k][j] sits in register 2k + j/2, slot j%2; drop the bits above the element
	always_comb begin
		for (int k = 0; k < m4rt_pkg::DIM; k++) begin
			for (int j = 0; j < m4rt_pkg::DIM; j++) begin
				b_mat[k][j] = m4rt_pkg::elem_t'(
					b_q[2*k + j/2][(j%2)*m4rt_pkg::SLOT_W +: m4rt_pkg::ELEM_W]);
			end
		end
	end

	assign a_row[0] = m4rt_pkg::elem_t'(row_in.a_elem0[m4rt_pkg::ELEM_W-1:0]);
	assign a_row[1] = m4rt_pkg::elem_t'(row_in.a_elem1[m4rt_pkg::ELEM_W-1:0]);
	assign a_row[2] = m4rt_pkg::elem_t'(row_in.a_elem2[m4rt_pkg::ELEM_W-1:0]);
	assign a_row[3] = m4rt_pkg::elem_t'(row_in.a_elem3[m4rt_pkg::ELEM_W-1:0]);

	m4rt_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (row_in.valid),
		.in_ready  (row_in.ready),
		.a_row     (a_row),
		.b_mat     (b_mat),
		.out_valid (v_s1),
		.out_ready (rdy_s1),
		.prod_s1   (prod_s1)
	);

	m4rt_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (rdy_s1),
		.prod_s1   (prod_s1),
		.out_valid (v_s3),
		.out_ready (rdy_s3),
		.sum_s3    (sum_s3)
	);

	m4rt_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (rdy_s3),
		.sum_s3    (sum_s3),
		.out_valid (row_out.valid),
		.out_ready (row_out.ready),
		.res_s4    (res_s4),
		.sat_s4    (sat_s4)
	);

	assign row_out.res_elem0 = res_s4[0];
	assign row_out.res_elem1 = res_s4[1];
	assign row_out.res_elem2 = res_s4[2];
	assign row_out.res_elem3 = res_s4[3];
	assign row_out.saturated = sat_s4;

	assign any_limit = row_out.res_elem0 == m4rt_pkg::FIELD_MAX
		|| row_out.res_elem0 == m4rt_pkg::FIELD_MIN
		|| row_out.res_elem1 == m4rt_pkg::FIELD_MAX
		|| row_out.res_elem1 == m4rt_pkg::FIELD_MIN
		|| row_out.res_elem2 == m4rt_pkg::FIELD_MAX
		|| row_out.res_elem2 == m4rt_pkg::FIELD_MIN
		|| row_out.res_elem3 == m4rt_pkg::FIELD_MAX
		|| row_out.res_elem3 == m4rt_pkg::FIELD_MIN;

	`M4RT_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, row_in.valid && row_in.ready, v_s1)
	`M4RT_ASSERT_NXT(a_s3_held_on_stall, clk, arst_n, v_s3 && !rdy_s3, v_s3)
	`M4RT_ASSERT_IMP(a_sat_at_limit, clk, arst_n, row_out.valid && row_out.saturated, any_limit)
	`M4RT_ASSERT_IMP(a_in_ready_when_s1_free, clk, arst_n, !v_s1, row_in.ready)

endmodule

[design/m4rt_mul.sv]
// Product stage: sixteen signed multiplies, registered.
module m4rt_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  m4rt_pkg::elem_row_t a_row,
	input  m4rt_pkg::elem_mat_t b_mat,
	output logic                out_valid,
	input  logic                out_ready,
	output m4rt_pkg::prod_mat_t prod_s1
);

	logic v_s1;

	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// prod_s1[j][k] = a[k] * B[k][j]
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int j = 0; j < m4rt_pkg::DIM; j++) begin
				for (int k = 0; k < m4rt_pkg::DIM; k++) begin
					prod_s1[j][k] <= m4rt_pkg::PROD_W'(a_row[k])
						* m4rt_pkg::PROD_W'(b_mat[k][j]);
				end
			end
		end
	end

endmodule

[design/m4rt_sum.sv]
// Adder tree: pair sums, then column sums, one level per stage.
module m4rt_sum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  m4rt_pkg::prod_mat_t prod_s1,
	output logic                out_valid,
	input  logic                out_ready,
	output m4rt_pkg::sum_row_t  sum_s3
);

	localparam int HALF = m4rt_pkg::DIM / 2;

	logic                v_s2;
	logic                v_s3;
	logic                rdy_s2;
	logic                rdy_s3;
	m4rt_pkg::pair_mat_t pair_s2;

	assign rdy_s3    = !v_s3 || out_ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign in_ready  = rdy_s2;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= in_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s2) begin
			for (int j = 0; j < m4rt_pkg::DIM; j++) begin
				for (int p = 0; p < HALF; p++) begin
					pair_s2[j][p] <= m4rt_pkg::PAIR_W'(prod_s1[j][2*p])
						+ m4rt_pkg::PAIR_W'(prod_s1[j][2*p+1]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			for (int j = 0; j < m4rt_pkg::DIM; j++) begin
				sum_s3[j] <= m4rt_pkg::SUM_W'(pair_s2[j][0])
					+ m4rt_pkg::SUM_W'(pair_s2[j][1]);
			end
		end
	end

endmodule

[design/m4rt_sat.sv]
// Output stage: floor shift, clip to element range, registered result word.
module m4rt_sat (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  m4rt_pkg::sum_row_t   sum_s3,
	output logic                 out_valid,
	input  logic                 out_ready,
	output m4rt_pkg::field_row_t res_s4,
	output logic                 sat_s4
);

	localparam int TOP_W = m4rt_pkg::SUM_W - m4rt_pkg::ELEM_W + 1;

	logic                 v_s4;
	m4rt_pkg::sum_t       shifted [m4rt_pkg::DIM];
	logic [m4rt_pkg::DIM-1:0] clip;
	m4rt_pkg::field_row_t res_d;

	assign in_ready  = !v_s4 || out_ready;
	assign out_valid = v_s4;

	always_comb begin
		for (int j = 0; j < m4rt_pkg::DIM; j++) begin
			shifted[j] = sum_s3[j] >>> m4rt_pkg::FRAC_BITS;
			// fits only if every bit above the element's sign matches it
			clip[j] = shifted[j][m4rt_pkg::SUM_W-1 -: TOP_W]
				!= {TOP_W{shifted[j][m4rt_pkg::SUM_W-1]}};
			if (!clip[j]) begin
				res_d[j] = m4rt_pkg::FIELD_W'(m4rt_pkg::elem_t'(
					shifted[j][m4rt_pkg::ELEM_W-1:0]));
			end else if (shifted[j][m4rt_pkg::SUM_W-1]) begin
				res_d[j] = m4rt_pkg::FIELD_MIN;
			end else begin
				res_d[j] = m4rt_pkg::FIELD_MAX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (in_ready) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_s4 <= res_d;
			sat_s4 <= |clip;
		end
	end

endmodule

[tb/row_transform_checker.sv]
// Checker for the 4x4 row transform: predicts every result row and compares it with the block.
`timescale 1ns / 100ps

module row_transform_checker
	import m4rt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	m4rt_in_if                   row_in,
	m4rt_out_if                  row_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   rows_pending
);

	typedef struct packed {
		logic                            sat;
		logic [DIM-1:0][FIELD_W-1:0]     elems;
	} row_result_t;

	localparam int PRINT_CAP = 40;

	cfg_word_t   b_regs [N_CFG];
	row_result_t due_rows [$];
	int          mismatches;
	int          rows_checked;

	assign fail_count = mismatches;

	initial begin
		mismatches   = 0;
		rows_checked = 0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t: row %0d %s: got %h, expected %h", $realtime, rows_checked, what,
				got, want);
	endtask

	function automatic elem_t b_entry(int k, int j);
		cfg_word_t w;
		w = b_regs[2 * k + j / 2];
		return elem_t'(w[(j % 2) * SLOT_W +: ELEM_W]);
	endfunction

	// Exact sum of four full-width products, floor shift, then clip to the element range.
	function automatic row_result_t transform_row(field_row_t a);
		row_result_t r;
		sum_t        acc;
		sum_t        scaled;
		prod_t       p;
		r = '0;
		for (int j = 0; j < DIM; j++) begin
			acc = '0;
			for (int k = 0; k < DIM; k++) begin
				p   = prod_t'(elem_t'(a[k])) * prod_t'(b_entry(k, j));
				acc = acc + sum_t'(p);
			end
			scaled = acc >>> FRAC_BITS;
			if (scaled > sum_t'(ELEM_MAX)) begin
				r.elems[j] = FIELD_MAX;
				r.sat      = 1'b1;
			end else if (scaled < sum_t'(ELEM_MIN)) begin
				r.elems[j] = FIELD_MIN;
				r.sat      = 1'b1;
			end else begin
				r.elems[j] = field_t'(elem_t'(scaled[ELEM_W-1:0]));
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		row_result_t got;
		row_result_t want;
		field_row_t  a;
		if (!arst_n) begin
			b_regs <= CFG_RESET;
			due_rows.delete();
			rows_pending <= 0;
		end else begin
			if (row_out.valid && row_out.ready) begin
				got.elems[0] = row_out.res_elem0;
				got.elems[1] = row_out.res_elem1;
				got.elems[2] = row_out.res_elem2;
				got.elems[3] = row_out.res_elem3;
				got.sat      = row_out.saturated;
				if (due_rows.size() == 0) begin
					report_mismatch("result word with no row waiting", got.elems[0], '0);
				end else begin
					want = due_rows.pop_front();
					for (int j = 0; j < DIM; j++)
						if (got.elems[j] !== want.elems[j])
							report_mismatch($sformatf("res_elem%0d", j), got.elems[j],
								want.elems[j]);
					if (got.sat !== want.sat)
						report_mismatch("saturated", 32'(got.sat), 32'(want.sat));
				end
				rows_checked++;
			end
			if (row_in.valid && row_in.ready) begin
				a[0] = row_in.a_elem0;
				a[1] = row_in.a_elem1;
				a[2] = row_in.a_elem2;
				a[3] = row_in.a_elem3;
				due_rows.push_back(transform_row(a));
			end
			// nonblocking, so a word taken at the write edge still sees the old matrix
			if (cfg_we)
				b_regs[cfg_index] <= cfg_data;
			rows_pending <= due_rows.size();
		end
	end

endmodule

[tb/testbench.sv]
// Top of the 4x4 row transform testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
	import m4rt_pkg::*;

	localparam int     RANDOM_BLOCKS  = 15;
	localparam int     ROWS_PER_BLOCK = 100;
	localparam int     STALL_CYCLES   = 300;
	localparam int     WATCHDOG_LIMIT = 3000;
	localparam int     DRAIN_CYCLES   = 12;
	localparam field_t ONE_FIELD      = field_t'(1) << FRAC_BITS;
	localparam elem_t  ONE_ELEM       = elem_t'(1) << FRAC_BITS;

	typedef enum int {
		MAT_SHAPED,
		MAT_RAW,
		MAT_SPECIAL,
		MAT_SMALL,
		MAT_CLIP
	} matrix_kind_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	cfg_word_t            cfg_data;
	int                   src_idle_pct;
	int                   snk_idle_pct;
	int                   stall_reqs;
	int                   fail_count;
	int                   rows_pending;
	int                   quiet_cycles;

	m4rt_in_if  row_in_ch ();
	m4rt_out_if row_out_ch ();

	matrix4x4_row_transform DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_in    (row_in_ch),
		.row_out   (row_out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	row_transform_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_in       (row_in_ch),
		.row_out      (row_out_ch),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.rows_pending (rows_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic field_t rand_elem();
		field_t v;
		if ($urandom_range(15) == 0) begin
			case ($urandom_range(2))
				0: v = FIELD_MAX;
				1: v = FIELD_MIN;
				default: v = '0;
			endcase
		end else begin
			v = field_t'($signed($urandom) >>> $urandom_range(31, 0));
		end
		return v;
	endfunction

	function automatic elem_mat_t uniform_matrix(elem_t v);
		elem_mat_t m;
		for (int k = 0; k < DIM; k++)
			for (int j = 0; j < DIM; j++)
				m[k][j] = v;
		return m;
	endfunction

	function automatic elem_mat_t random_matrix(matrix_kind_t kind);
		elem_mat_t m;
		for (int k = 0; k < DIM; k++)
			for (int j = 0; j < DIM; j++)
				case (kind)
					MAT_SHAPED: m[k][j] = elem_t'(rand_elem());
					MAT_RAW:    m[k][j] = elem_t'($urandom);
					MAT_SPECIAL: begin
						case ($urandom_range(6))
							0: m[k][j] = ELEM_MAX;
							1: m[k][j] = ELEM_MIN;
							2: m[k][j] = '0;
							3: m[k][j] = ONE_ELEM;
							4: m[k][j] = -ONE_ELEM;
							5: m[k][j] = elem_t'(1);
							default: m[k][j] = elem_t'(-1);
						endcase
					end
					// keep most sums inside range
					MAT_SMALL: m[k][j] = elem_t'($signed($urandom) >>> $urandom_range(31, 12));
					default:   m[k][j] = $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
				endcase
		return m;
	endfunction

	// Called just after a rising edge; leaves the write enable low.
	task automatic load_matrix(input elem_mat_t m);
		for (int i = 0; i < N_CFG; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= {m[i / 2][(i % 2) * 2 + 1], m[i / 2][(i % 2) * 2]};
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Returns at the edge that takes the word, with valid still high.
	task automatic send_row(input field_t e0, input field_t e1, input field_t e2,
		input field_t e3);
		while ($urandom_range(99) < src_idle_pct) begin
			row_in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		row_in_ch.valid   <= 1'b1;
		row_in_ch.a_elem0 <= e0;
		row_in_ch.a_elem1 <= e1;
		row_in_ch.a_elem2 <= e2;
		row_in_ch.a_elem3 <= e3;
		@(posedge clk);
		while (row_in_ch.ready !== 1'b1)
			@(posedge clk);
	endtask

	// Drop valid and hold until every predicted row has come out.
	task automatic finish_rows();
		row_in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (rows_pending != 0);
	endtask

	// Receiver: random back-pressure, plus a long hold-off on request.
	initial begin
		int stall_seen;
		int hold_left;
		stall_seen       = 0;
		hold_left        = 0;
		row_out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				row_out_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_reqs != stall_seen) begin
				stall_seen       = stall_reqs;
				hold_left        = STALL_CYCLES;
				row_out_ch.ready <= 1'b0;
			end else begin
				row_out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((row_in_ch.valid && row_in_ch.ready) || (row_out_ch.valid && row_out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		row_in_ch.valid   = 1'b0;
		row_in_ch.a_elem0 = '0;
		row_in_ch.a_elem1 = '0;
		row_in_ch.a_elem2 = '0;
		row_in_ch.a_elem3 = '0;
		src_idle_pct      = 0;
		snk_idle_pct      = 0;
		stall_reqs        = 0;
		arst_n            = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity from reset: every row passes through, extremes fit exactly
		send_row('0, '0, '0, '0);
		send_row(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
		send_row(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN);
		send_row(FIELD_MAX, FIELD_MIN, field_t'(-1), field_t'(1));
		send_row(ONE_FIELD, -ONE_FIELD, 32'sh12345678, field_t'(32'hEDCBA987));
		finish_rows();

		// all ones: the row is summed, one past either end clips
		load_matrix(uniform_matrix(ONE_ELEM));
		send_row(FIELD_MAX, field_t'(1), '0, '0);
		send_row(FIELD_MIN, field_t'(-1), '0, '0);
		send_row(FIELD_MAX, '0, '0, '0);
		send_row(FIELD_MIN, '0, '0, '0);
		send_row(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
		finish_rows();

		// smallest step: the shift rounds towards minus infinity
		load_matrix(uniform_matrix(elem_t'(1)));
		send_row(field_t'(1), '0, '0, '0);
		send_row(field_t'(-1), '0, '0, '0);
		send_row(field_t'(32'h0000FFFF), field_t'(1), '0, '0);
		finish_rows();

		load_matrix(uniform_matrix(ELEM_MAX));
		send_row(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
		send_row(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN);
		send_row(field_t'(-1), '0, '0, '0);
		finish_rows();

		load_matrix(uniform_matrix(ELEM_MIN));
		send_row(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN);
		send_row(field_t'(1), field_t'(1), field_t'(1), field_t'(1));
		finish_rows();

		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			if (blk == 0) begin
				src_idle_pct <= 32;
				snk_idle_pct <= 49;
			end else if (blk == 5) begin
				src_idle_pct <= 49;
				snk_idle_pct <= 32;
			end else if (blk == 10) begin
				src_idle_pct <= 0;
				snk_idle_pct <= 0;
			end
			load_matrix(random_matrix(matrix_kind_t'(blk % 5)));
			// keep offering words while the receiver holds off, so the pipe fills
			if (blk == 12)
				stall_reqs <= stall_reqs + 1;
			repeat (ROWS_PER_BLOCK)
				send_row(rand_elem(), rand_elem(), rand_elem(), rand_elem());
			finish_rows();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && rows_pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
